// ===== sv/lkvc_pkg.sv =====
// Shared types and constants of the LRU key/value cache.
package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CFG_FIELD_W = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [CFG_FIELD_W-1:0] ENTRIES_IN_USE_RESET = CFG_FIELD_W'(16);

    // Register index, taken from the word address bit of the APB port.
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        MODE_GET = 1'b0,
        MODE_PUT = 1'b1
    } t_mode;

    // Source of the read value in the result beat.
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_MISS = 2'd1,
        RD_DATA = 2'd2
    } t_rd_sel;

endpackage

// ===== sv/lkvc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lru_key_value_cache_unit.sv =====
// Top level of the fully associative LRU key/value cache.
//
// Usage: an item (mode, key, value) is taken at a rising edge where start is high
// and busy is low. busy stays low, so a new item may be issued in every cycle.
// mode 0 is a get, mode 1 is a put. The item is held in an input register; during
// the following cycle the keys of all entries are compared in parallel, the
// recency ranks are updated and the result is loaded into the output registers.
// o_done is set from the result register, behind the input register, and is high
// for exactly one cycle; the receiver must take the beat in that cycle, as it
// cannot stall the block. Throughput is one item per cycle; each item passes
// through the input register and then the result register, and the limit is the
// key compare and age update across all entries.
// Stored values live in a small RAM whose registered read port supplies
// o_read_value during the result cycle.
// The APB port holds one register, entries_in_use, at byte address 0. It should be
// written only while no item is in flight.
// Reset (synchronous, active low) empties the cache, clears all recency ranks and
// sets entries_in_use to 16. Keys and values need no clearing since only valid
// entries are ever compared or read.
module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] i_value,
    output logic                              o_done,
    output logic                              o_hit,
    output logic signed [lkvc_pkg::VAL_W-1:0] o_read_value,
    output logic                              o_evicted,
    output logic signed [lkvc_pkg::KEY_W-1:0] o_evicted_key,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkvc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lkvc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [lkvc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    import lkvc_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AGE_W = IDX_W;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CFG_FIELD_W) ? OCC_W : CFG_FIELD_W;

    // Configuration register.
    logic [CFG_FIELD_W-1:0] r_entries_in_use;
    logic                   w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready
                         && (paddr[2] == REG_ENTRIES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= ENTRIES_IN_USE_RESET;
        end else if (w_cfg_write) begin
            r_entries_in_use <= pwdata[CFG_FIELD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ENTRIES_IN_USE)
                    ? CFG_DATA_W'(r_entries_in_use) : '0;

    // The datapath takes one item per cycle, so it never pushes back.
    assign busy = 1'b0;

    // Input register.
    logic             r_in_valid;
    t_mode            r_mode;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode  <= t_mode'(i_mode);
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // Cache state. Keys sit in flops so that every entry can be compared at once.
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [AGE_W-1:0]       r_age [MAX_ENTRIES];
    logic [KEY_W-1:0]       r_ekey [MAX_ENTRIES];
    logic [OCC_W-1:0]       r_occ;

    logic [MAX_ENTRIES-1:0] n_valid;
    logic [AGE_W-1:0]       n_age [MAX_ENTRIES];
    logic [OCC_W-1:0]       n_occ;

    // Lookup and replacement decisions.
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_free;
    logic [MAX_ENTRIES-1:0] w_first_free;
    logic [MAX_ENTRIES-1:0] w_lru;
    logic [MAX_ENTRIES-1:0] w_target;
    logic                   w_found;
    logic [AGE_W-1:0]       w_found_age;
    logic [AGE_W-1:0]       w_lru_age;
    logic [AGE_W-1:0]       w_old_age;
    logic [CMP_W-1:0]       w_cap;
    logic                   w_has_room;
    logic                   w_insert;
    logic                   w_evict;
    logic                   w_promote;
    logic                   w_key_write;
    logic [KEY_W-1:0]       w_evict_key;
    logic [IDX_W-1:0]       w_match_idx;
    logic [IDX_W-1:0]       w_target_idx;

    always_comb begin
        if (r_entries_in_use == '0) begin
            w_cap = CMP_W'(1);
        end else if (CMP_W'(r_entries_in_use) > CMP_W'(MAX_ENTRIES)) begin
            w_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            w_cap = CMP_W'(r_entries_in_use);
        end
    end

    assign w_has_room = CMP_W'(r_occ) < w_cap;
    // Ranks form a permutation of 0..occupancy-1, so the oldest entry has rank
    // occupancy-1.
    assign w_lru_age  = AGE_W'(r_occ - OCC_W'(1));

    // Lowest free slot: isolate the least significant set bit.
    assign w_free       = ~r_valid;
    assign w_first_free = w_free & (~w_free + MAX_ENTRIES'(1));

    always_comb begin
        w_found_age = '0;
        w_evict_key = '0;
        w_match_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_ekey[i] == r_key);
            w_lru[i]   = r_valid[i] && (r_age[i] == w_lru_age);
            if (w_match[i]) begin
                w_found_age = w_found_age | r_age[i];
                w_match_idx = w_match_idx | IDX_W'(i);
            end
            if (w_lru[i]) begin
                w_evict_key = w_evict_key | r_ekey[i];
            end
        end
    end

    assign w_found     = |w_match;
    assign w_insert    = r_in_valid && (r_mode == MODE_PUT) && !w_found && w_has_room;
    assign w_evict     = r_in_valid && (r_mode == MODE_PUT) && !w_found && !w_has_room;
    assign w_promote   = r_in_valid && (w_found || r_mode == MODE_PUT);
    assign w_key_write = w_insert || w_evict;

    always_comb begin
        if (w_found) begin
            w_target  = w_match;
            w_old_age = w_found_age;
        end else if (w_has_room) begin
            w_target  = w_first_free;
            w_old_age = w_found_age;
        end else begin
            w_target  = w_lru;
            w_old_age = w_lru_age;
        end
    end

    always_comb begin
        w_target_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_target[i]) begin
                w_target_idx = w_target_idx | IDX_W'(i);
            end
        end
    end

    // Recency update: the touched entry becomes rank 0 and every valid entry that
    // was younger than it moves back one rank. A fresh insert ages all of them.
    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_age[i] = r_age[i];
            if (w_promote) begin
                if (w_target[i]) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && (w_insert || r_age[i] < w_old_age)) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
        end
        if (w_insert) begin
            n_valid = r_valid | w_target;
            n_occ   = r_occ + OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_key_write && w_target[i]) begin
                r_ekey[i] <= r_key;
            end
        end
    end

    // Value store: a put writes the target slot, a get hit reads the matching
    // slot, and the registered read lands in the result cycle.
    logic [VAL_W-1:0] w_ram_rdata;
    logic             w_ram_we;
    logic             w_ram_re;

    assign w_ram_we = r_in_valid && (r_mode == MODE_PUT);
    assign w_ram_re = r_in_valid && (r_mode == MODE_GET) && w_found;

    lkvc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_target_idx),
        .i_wdata (r_value),
        .i_re    (w_ram_re),
        .i_raddr (w_match_idx),
        .o_rdata (w_ram_rdata)
    );

    // Result register.
    logic             r_done;
    logic             r_hit;
    t_rd_sel          r_rd_sel;
    logic             r_evicted;
    logic [KEY_W-1:0] r_evicted_key;
    t_rd_sel          n_rd_sel;

    always_comb begin
        if (r_mode == MODE_PUT) begin
            n_rd_sel = RD_ZERO;
        end else if (w_found) begin
            n_rd_sel = RD_DATA;
        end else begin
            n_rd_sel = RD_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_hit         <= w_found;
            r_rd_sel      <= n_rd_sel;
            r_evicted     <= w_evict;
            r_evicted_key <= w_evict ? w_evict_key : '0;
        end
    end

    always_comb begin
        case (r_rd_sel)
            RD_DATA: o_read_value = w_ram_rdata;
            RD_MISS: o_read_value = MISS_VALUE;
            RD_ZERO: o_read_value = '0;
            default: o_read_value = '0;
        endcase
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

`ifndef SYNTHESIS
    // The fill count must track the number of valid entries exactly.
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_occ))
        else $error("occupancy does not match the number of valid entries");

    // Keys are unique among valid entries, so a lookup hits at most one entry.
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(w_match))
        else $error("key matched more than one entry");

    // An eviction needs exactly one oldest entry to replace.
    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_evict |-> $onehot(w_lru))
        else $error("eviction without a unique least recent entry");

    // An eviction beat never reports a hit.
    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> !o_hit)
        else $error("eviction reported together with a hit");
`endif

endmodule
